// ----- hw/rtl/aes_pkg.sv -----
// ----------------------------------------------------------------------------
// aes_pkg: shared types and constants for the AES-128 block cipher
// Action codes, state codes, key store sizing and the GF(2^8) doubling helper.
// ----------------------------------------------------------------------------
package aes_pkg;

   localparam int ROUNDS    = 10;
   localparam int KEY_WORDS = 4 * (ROUNDS + 1);
   localparam int KEY_AW    = $clog2(KEY_WORDS);
   localparam int RND_W     = $clog2(ROUNDS + 1);

   typedef enum logic [1:0] {
      ACT_LOAD_KEY  = 2'd0,
      ACT_LOAD_SBOX = 2'd1,
      ACT_ENCRYPT   = 2'd2,
      ACT_NONE      = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ARK,
      ST_SUB,
      ST_MIX,
      ST_DONE
   } state_type;

   function automatic logic [7:0] gf_double(input logic [7:0] b);
      gf_double = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

endpackage

// ----- hw/rtl/aes128_block_encrypt.sv -----
// ----------------------------------------------------------------------------
// aes128_block_encrypt: AES-128 block encryption with loaded keys and S-box
// Memory-based iterative cipher: one S-box byte per cycle, one key word per
// cycle.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one word per item: action 0 writes round-key
//   word req_index (0..43, others dropped), action 1 writes S-box byte
//   req_index from req_load_word[7:0], action 2 encrypts req_block_hi/lo.
//   Action 3 is dropped. Loads give no result.
//   An encryption gives one rsp_ word with the ciphertext, byte 0 in the
//   top bits of rsp_cipher_hi.
// Schedule:
//   One S-box read port sets the rate. Per block: the first AddRoundKey,
//   9 rounds of SubBytes, MixColumns and AddRoundKey, a last round of
//   SubBytes and AddRoundKey, then a hand-off step that raises rsp_valid.
//   req_stall is high while busy, so no new word is taken until the block is done.
// Reset:
//   Clears the control state only. Key and S-box memories hold garbage
//   until written and must be loaded before the first encryption.
// Stall:
//   Hold a finished result in the rsp_ registers while rsp_stall is high.
//   Loads are still taken; a following encryption holds in its last step.
// ----------------------------------------------------------------------------
module aes128_block_encrypt (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_index,
   input  logic [31:0] req_load_word,
   input  logic [63:0] req_block_hi,
   input  logic [63:0] req_block_lo,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_cipher_hi,
   output logic [63:0] rsp_cipher_lo
);
   import aes_pkg::*;

   logic [31:0] key_mem [KEY_WORDS];
   logic [7:0]  sbox_mem [256];

   state_type   state_ff, state_in;
   logic [127:0] blk_ff, blk_in;       // byte n at [127-8n -: 8]
   logic [RND_W-1:0] rnd_ff, rnd_in;
   logic [4:0]  cnt_ff, cnt_in;        // step within the phase
   logic        rsp_valid_ff, rsp_valid_in;
   logic [127:0] rsp_ff, rsp_in;
   logic [127:0] sub_ff, sub_in;       // substituted bytes shift in here

   logic        accept;
   logic [31:0] key_q_ff;
   logic [7:0]  sbox_q_ff;
   logic [KEY_AW-1:0] key_ra;
   logic [7:0]  sbox_ra;
   logic [3:0]  src_byte;
   logic [1:0]  ark_col;
   logic [127:0] mixed;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // loads into the memories and registered memory reads
   always_ff @(posedge clock) begin
      if (accept && req_action == ACT_LOAD_KEY && req_index < 8'(KEY_WORDS))
         key_mem[req_index[KEY_AW-1:0]] <= req_load_word;
      if (accept && req_action == ACT_LOAD_SBOX)
         sbox_mem[req_index] <= req_load_word[7:0];
      key_q_ff  <= key_mem[key_ra];
      sbox_q_ff <= sbox_mem[sbox_ra];
   end

   // ARK: cnt 0..3 issue key reads, 1..4 use data. SUB: cnt 0..15 issue, 1..16 use.
   assign key_ra = KEY_AW'({rnd_ff, 2'b00} + {{(RND_W){1'b0}}, cnt_ff[1:0]});
   assign ark_col = cnt_ff[1:0] - 2'd1;
   // ShiftRows: output byte 4c+r takes input byte 4((c+r)&3)+r
   assign src_byte = {cnt_ff[3:2] + cnt_ff[1:0], cnt_ff[1:0]};
   assign sbox_ra  = blk_ff[127 - 8*src_byte -: 8];

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         logic [7:0] a0, a1, a2, a3;
         a0 = blk_ff[127 - 8*(4*c)   -: 8];
         a1 = blk_ff[127 - 8*(4*c+1) -: 8];
         a2 = blk_ff[127 - 8*(4*c+2) -: 8];
         a3 = blk_ff[127 - 8*(4*c+3) -: 8];
         mixed[127 - 8*(4*c)   -: 8] = gf_double(a0) ^ gf_double(a1) ^ a1 ^ a2 ^ a3;
         mixed[127 - 8*(4*c+1) -: 8] = a0 ^ gf_double(a1) ^ gf_double(a2) ^ a2 ^ a3;
         mixed[127 - 8*(4*c+2) -: 8] = a0 ^ a1 ^ gf_double(a2) ^ gf_double(a3) ^ a3;
         mixed[127 - 8*(4*c+3) -: 8] = gf_double(a0) ^ a0 ^ a1 ^ a2 ^ gf_double(a3);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept && req_action == ACT_ENCRYPT) state_in = ST_ARK;
         ST_ARK:  if (cnt_ff == 5'd4)
                     state_in = (rnd_ff == RND_W'(ROUNDS)) ? ST_DONE : ST_SUB;
         ST_SUB:  if (cnt_ff == 5'd16)
                     state_in = (rnd_ff == RND_W'(ROUNDS)) ? ST_ARK : ST_MIX;
         ST_MIX:  state_in = ST_ARK;
         ST_DONE: if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      blk_in       = blk_ff;
      rnd_in       = rnd_ff;
      cnt_in       = cnt_ff;
      rsp_in       = rsp_ff;
      sub_in       = sub_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            blk_in = {req_block_hi, req_block_lo};
            rnd_in = '0;
            cnt_in = '0;
         end
         ST_ARK: begin
            if (cnt_ff != 5'd0)
               blk_in[127 - 32*ark_col -: 32] = blk_ff[127 - 32*ark_col -: 32] ^ key_q_ff;
            cnt_in = (cnt_ff == 5'd4) ? 5'd0 : cnt_ff + 5'd1;
            if (cnt_ff == 5'd4) rnd_in = rnd_ff + RND_W'(1);
         end
         ST_SUB: begin
            // shift substituted bytes in; byte 0 ends on top
            if (cnt_ff != 5'd0)
               sub_in = {sub_ff[119:0], sbox_q_ff};
            if (cnt_ff == 5'd16) begin
               blk_in = {sub_ff[119:0], sbox_q_ff};
               cnt_in = 5'd0;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         ST_MIX: blk_in = mixed;
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = blk_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rnd_ff       <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rnd_ff       <= rnd_in;
         cnt_ff       <= cnt_in;
      end
      blk_ff <= blk_in;
      rsp_ff <= rsp_in;
      sub_ff <= sub_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cipher_hi = rsp_ff[127:64];
   assign rsp_cipher_lo = rsp_ff[63:0];

endmodule

// ----- hw/rtl/aes_checker.sv -----
// ----------------------------------------------------------------------------
// aes_checker: port-level checks for the AES-128 block cipher
// Watches the request and response channels over time.
// ----------------------------------------------------------------------------
module aes_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_action,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_cipher_hi,
   input logic [63:0] rsp_cipher_lo
);
   import aes_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cipher_hi)
                                 && $stable(rsp_cipher_lo))
      else $error("stalled result changed");

   a_enc_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_action == ACT_ENCRYPT |=> req_stall)
      else $error("encrypt did not block input");

   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && req_valid && !req_stall && req_action != ACT_ENCRYPT
      |=> !rsp_valid)
      else $error("result without encryption");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("not idle after reset");

endmodule

bind aes128_block_encrypt aes_checker u_aes_checker (.*);
